// ===== design/kvs_pkg.sv =====
`timescale 1ns / 1ps

package kvs_pkg;

  // Request opcodes.
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_ERASE  = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_COUNT  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_DUP      = 2'd3;

  // Cells reduced per scan cycle.
  localparam int GROUP = 8;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [31:0]        key;
    logic signed [31:0] value;
  } kvs_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] read_value;
    logic [5:0]         match_count;
    logic [5:0]         entry_count;
  } kvs_out_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic era_en;
  } cell_ctl_t;

endpackage

// ===== design/kvs_cell.sv =====
`timescale 1ns / 1ps

module kvs_cell import kvs_pkg::*; #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int FILL_W     = 6,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [FILL_W-1:0]     fill,
  input  logic [KEY_BITS-1:0]   cmp_key,
  input  logic [VALUE_BITS-1:0] cmp_val,
  input  logic [KEY_BITS-1:0]   wr_key,
  input  logic [VALUE_BITS-1:0] wr_val,
  input  logic [KEY_BITS-1:0]   nb_key,
  input  logic [VALUE_BITS-1:0] nb_val,
  input  logic                  shift_in,
  output logic                  shift_out,
  output logic [KEY_BITS-1:0]   key_q,
  output logic [VALUE_BITS-1:0] val_q,
  output logic                  hit_q,
  output logic                  match_q
);

  localparam logic [FILL_W-1:0] MY_IDX = FILL_W'(IDX);

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  hit_r;
  logic                  match_r;
  logic                  live;

  assign live      = MY_IDX < fill;
  // The hit travels up the row so that every cell above the erased entry moves down.
  assign shift_out = shift_in | hit_r;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      hit_r   <= live && (key_r == cmp_key);
      match_r <= live && (val_r == cmp_val);
    end
    if (ctl.era_en && shift_out) begin
      key_r <= nb_key;
      val_r <= nb_val;
    end else if (ctl.ins_en && (MY_IDX == fill)) begin
      key_r <= wr_key;
      val_r <= wr_val;
    end
  end

  assign key_q   = key_r;
  assign val_q   = val_r;
  assign hit_q   = hit_r;
  assign match_q = match_r;

endmodule

// ===== design/keyed_value_store.sv =====
`timescale 1ns / 1ps

// Channel  Ports                      Handshake
// -------  -------------------------  ---------------------------------------
// request  start, busy, in_data       item taken at clk when start && !busy
// result   out_valid, out_data        one-cycle strobe, always taken
//
// Insert, erase, clear and unused opcodes pass through the accept cycle, in
// which every cell compares its entry, and then the execute state. Lookup and
// count add a scan over the cells, GROUP of them at a time. The result shows
// in the cycle after the last step, and a new item may be taken in that same
// cycle. Reset is synchronous and empties the table; the entry storage is not
// cleared. The receiver cannot stall the block.

module keyed_value_store import kvs_pkg::*; #(
  parameter int DEPTH      = 32,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  kvs_in_t  in_data,
  output logic     out_valid,
  output kvs_out_t out_data
);

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int NG     = (DEPTH + GROUP - 1) / GROUP;
  localparam int GW     = (NG > 1) ? $clog2(NG) : 1;
  localparam int NP     = (2 ** GW) * GROUP;

  // One-hot controller states.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  kvs_in_t             req_r;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [GW-1:0]       grp_r, grp_nxt;
  logic [FILL_W-1:0]   cnt_acc_r, cnt_acc_nxt;
  logic [VALUE_BITS-1:0] rv_acc_r, rv_acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  kvs_out_t            out_r, out_nxt;

  logic                  accept;
  cell_ctl_t             ctl;
  logic [KEY_BITS-1:0]   cmp_key, wr_key;
  logic [VALUE_BITS-1:0] cmp_val, wr_val;

  logic [KEY_BITS-1:0]   key_q [DEPTH];
  logic [VALUE_BITS-1:0] val_q [DEPTH];
  logic [DEPTH-1:0]      hit_vec;
  logic [DEPTH-1:0]      match_vec;
  logic [DEPTH:0]        shift_chain;

  logic [NP-1:0]                  hit_pad;
  logic [NP-1:0]                  match_pad;
  logic [NP-1:0][VALUE_BITS-1:0]  val_pad;

  logic [FILL_W-1:0]     grp_cnt;
  logic [VALUE_BITS-1:0] grp_val;
  logic                  any_hit;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Keys are zero-extended or cut to KEY_BITS, values sign-extended or cut.
  assign cmp_key = KEY_BITS'(in_data.key);
  assign cmp_val = VALUE_BITS'(in_data.value);
  assign wr_key  = KEY_BITS'(req_r.key);
  assign wr_val  = VALUE_BITS'(req_r.value);

  assign shift_chain[0] = 1'b0;

  // The row of cells. On an erase, those from the hit up take the entry above.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]   nb_key;
    logic [VALUE_BITS-1:0] nb_val;

    if (i == DEPTH - 1) begin : g_top
      assign nb_key = key_q[i];
      assign nb_val = val_q[i];
    end else begin : g_mid
      assign nb_key = key_q[i + 1];
      assign nb_val = val_q[i + 1];
    end

    kvs_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS),
      .FILL_W    (FILL_W),
      .IDX       (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .fill     (fill_r),
      .cmp_key  (cmp_key),
      .cmp_val  (cmp_val),
      .wr_key   (wr_key),
      .wr_val   (wr_val),
      .nb_key   (nb_key),
      .nb_val   (nb_val),
      .shift_in (shift_chain[i]),
      .shift_out(shift_chain[i + 1]),
      .key_q    (key_q[i]),
      .val_q    (val_q[i]),
      .hit_q    (hit_vec[i]),
      .match_q  (match_vec[i])
    );
  end

  // Pad the cell outputs to a whole number of groups so that the scan can
  // index them by group number without a range check.
  assign hit_pad   = NP'(hit_vec);
  assign match_pad = NP'(match_vec);
  for (genvar i = 0; i < NP; i++) begin : g_pad
    if (i < DEPTH) begin : g_real
      assign val_pad[i] = val_q[i];
    end else begin : g_none
      assign val_pad[i] = '0;
    end
  end

  // Keys are unique, so at most one cell hits and the OR picks its value.
  always_comb begin
    logic [GW+2:0] idx;
    grp_cnt = '0;
    grp_val = '0;
    for (int j = 0; j < GROUP; j++) begin
      idx     = {grp_r, 3'(j)};
      grp_cnt = grp_cnt + FILL_W'(match_pad[idx]);
      if (hit_pad[idx]) begin
        grp_val = grp_val | val_pad[idx];
      end
    end
  end

  assign any_hit = |hit_vec;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    grp_nxt       = grp_r;
    cnt_acc_nxt   = cnt_acc_r;
    rv_acc_nxt    = rv_acc_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ctl           = '0;
    ctl.cmp_en    = accept;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        out_nxt   = '0;
        state_nxt = S_IDLE;
        unique case (req_r.opcode) inside
          OP_INSERT: begin
            // A full table is reported ahead of a duplicate key.
            if (fill_r == FILL_W'(DEPTH)) begin
              out_nxt.status = ST_FULL;
            end else if (any_hit) begin
              out_nxt.status = ST_DUP;
            end else begin
              ctl.ins_en = 1'b1;
              fill_nxt   = fill_r + 1'b1;
            end
            out_valid_nxt = 1'b1;
          end
          OP_ERASE: begin
            if (any_hit) begin
              ctl.era_en    = 1'b1;
              fill_nxt      = fill_r - 1'b1;
              out_nxt.found = 1'b1;
            end else begin
              out_nxt.status = ST_NOTFOUND;
            end
            out_valid_nxt = 1'b1;
          end
          OP_CLEAR: begin
            fill_nxt      = '0;
            out_valid_nxt = 1'b1;
          end
          OP_LOOKUP, OP_COUNT: begin
            state_nxt   = S_SCAN;
            grp_nxt     = '0;
            cnt_acc_nxt = '0;
            rv_acc_nxt  = '0;
          end
          default: begin
            // Unused opcodes leave the table alone and report only its size.
            out_valid_nxt = 1'b1;
          end
        endcase
        out_nxt.entry_count = 6'(fill_nxt);
      end

      S_SCAN: begin
        grp_nxt     = grp_r + 1'b1;
        cnt_acc_nxt = cnt_acc_r + grp_cnt;
        rv_acc_nxt  = rv_acc_r | grp_val;
        if (grp_r == GW'(NG - 1)) begin
          state_nxt           = S_IDLE;
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.entry_count = 6'(fill_r);
          if (req_r.opcode == OP_COUNT) begin
            out_nxt.match_count = 6'(cnt_acc_nxt);
          end else if (any_hit) begin
            out_nxt.found      = 1'b1;
            out_nxt.read_value = 32'(signed'(rv_acc_nxt));
          end else begin
            out_nxt.status = ST_NOTFOUND;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    grp_r     <= grp_nxt;
    cnt_acc_r <= cnt_acc_nxt;
    rv_acc_r  <= rv_acc_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/kvs_checker.sv =====
`timescale 1ns / 1ps

module kvs_assertions import kvs_pkg::*; #(
  parameter int DEPTH = 32
) (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input kvs_in_t  in_data,
  input logic     out_valid,
  input kvs_out_t out_data
);

  // Every item passes through the execute state, so strobes never touch.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in adjacent cycles");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after taking an item");

  a_full_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> out_data.entry_count == 6'(DEPTH))
    else $error("table full reported with a size other than capacity");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found) |-> out_data.status == ST_OK)
    else $error("key found but status not ok");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.entry_count) <= DEPTH) || (DEPTH > 63))
    else $error("size beyond capacity");

endmodule

bind keyed_value_store kvs_assertions #(.DEPTH(DEPTH)) u_kvs_assertions (.*);
